// ===== hdl/bmrf_pkg.sv =====
// shared types, constants and codes for the bitmap run modify and find block
package bmrf_pkg;

    localparam int BITMAP_BYTES = 4096;
    localparam int ADDR_W       = 12;
    localparam int MAX_RUN      = 1024;
    localparam logic [15:0] SIZE_CAP = 16'd32768;

    // request codes
    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_READ   = 3'd1;
    localparam logic [2:0] REQ_SET    = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_INVERT = 3'd4;
    localparam logic [2:0] REQ_FIND   = 3'd5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ_RD,
        ST_READ_EVAL,
        ST_EDIT_RD,
        ST_EDIT_WR,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_RUN_RD,
        ST_RUN_EVAL
    } state_t;

    // request to the shared byte unit
    typedef struct packed {
        logic [7:0] data;
        logic [2:0] op;
        logic [2:0] lo;
        logic [2:0] hi;
        logic [2:0] start;
        logic [7:0] vmask;
    } alu_req_t;

    // answer of the shared byte unit
    typedef struct packed {
        logic [7:0] edited;
        logic       any;
        logic [2:0] fpos;
        logic [3:0] cnt;
    } alu_rsp_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [11:0] byte_index;
        logic [7:0]  byte_value;
        logic [14:0] bit_offset;
        logic [15:0] run_length;
    } req_t;

    typedef struct packed {
        logic        status;
        logic [7:0]  read_data;
        logic [12:0] bytes_changed;
        logic [11:0] first_byte;
        logic [14:0] found_offset;
        logic [10:0] found_length;
        logic [15:0] next_start;
    } res_t;

endpackage

// ===== hdl/bmrf_mem.sv =====
// bitmap byte store, one write port and one registered read port
module bmrf_mem (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [bmrf_pkg::ADDR_W-1:0] waddr,
    input  logic [7:0]                  wdata,
    input  logic [bmrf_pkg::ADDR_W-1:0] raddr,
    output logic [7:0]                  rdata
);
    import bmrf_pkg::*;

    logic [7:0] mem [BITMAP_BYTES];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== hdl/bmrf_byte_alu.sv =====
// shared byte unit: run edit of one byte, first set bit and run of ones
module bmrf_byte_alu (
    input  bmrf_pkg::alu_req_t req,
    output bmrf_pkg::alu_rsp_t rsp
);
    import bmrf_pkg::*;

    logic [7:0] emask;
    logic [7:0] edited;
    logic [7:0] valid;
    logic [7:0] m;
    logic [7:0] v;
    logic [2:0] fpos;
    logic [3:0] cnt;
    logic       run_on;

    // edit mask from lo to hi inclusive
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            emask[i] = (3'(i) >= req.lo) && (3'(i) <= req.hi);
        end
    end

    // apply the edit
    always_comb begin
        case (req.op)
            REQ_SET:   edited = req.data | emask;
            REQ_CLEAR: edited = req.data & ~emask;
            default:   edited = req.data ^ emask;
        endcase
    end

    // lowest set bit at or above start, then ones from there
    always_comb begin
        valid = req.data & req.vmask;
        m     = valid & (8'hFF << req.start);
        fpos  = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (m[i]) begin
                fpos = 3'(i);
            end
        end
        v      = valid >> fpos;
        cnt    = 4'd0;
        run_on = 1'b1;
        for (int i = 0; i < 8; i++) begin
            if (run_on && v[i]) begin
                cnt = cnt + 4'd1;
            end else begin
                run_on = 1'b0;
            end
        end
        rsp.edited = edited;
        rsp.any    = |m;
        rsp.fpos   = fpos;
        rsp.cnt    = cnt;
    end
endmodule

// ===== hdl/bmrf_seq.sv =====
// sequencer: clearing pass, byte walks for edits and searches, result register
module bmrf_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  bmrf_pkg::req_t   req,
    input  logic [15:0]      size_n,
    output logic             m_valid,
    input  logic             m_ready,
    output bmrf_pkg::res_t   res
);
    import bmrf_pkg::*;

    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ADDR_W-1:0]  first_reg, first_next;
    logic [ADDR_W-1:0]  last_reg, last_next;
    logic [2:0]         lo_reg, lo_next;
    logic [2:0]         hi_reg, hi_next;
    logic [2:0]         start_reg, start_next;
    logic [2:0]         op_reg, op_next;
    logic [15:0]        n_reg, n_next;
    logic [14:0]        p_reg, p_next;
    logic [10:0]        run_reg, run_next;
    logic [12:0]        nchg_reg, nchg_next;
    res_t               res_reg, res_next;
    logic               out_valid_reg, out_valid_next;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [7:0]         mem_wdata;
    logic [7:0]         mem_rdata;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;

    logic               s_fire;
    logic [16:0]        end_bit;
    logic [15:0]        off_ext;
    logic [15:0]        byte_end;
    logic [12:0]        n_byte;
    logic [7:0]         vmask;
    logic [11:0]        run_sum;
    logic [3:0]         k;

    bmrf_mem u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    bmrf_byte_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign s_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign res     = res_reg;

    // request decode helpers
    assign off_ext = {1'b0, req.bit_offset};
    assign end_bit = {2'b00, req.bit_offset} + {1'b0, req.run_length} - 17'd1;

    // bits of the current byte that lie inside the bitmap
    assign n_byte   = n_reg[15:3];
    assign byte_end = {({1'b0, addr_reg} + 13'd1), 3'b000};
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            if ({1'b0, addr_reg} < n_byte) begin
                vmask[i] = 1'b1;
            end else if ({1'b0, addr_reg} == n_byte) begin
                vmask[i] = 3'(i) < n_reg[2:0];
            end else begin
                vmask[i] = 1'b0;
            end
        end
    end

    // shared unit inputs
    always_comb begin
        alu_req.data  = mem_rdata;
        alu_req.op    = op_reg;
        alu_req.lo    = (addr_reg == first_reg) ? lo_reg : 3'd0;
        alu_req.hi    = (addr_reg == last_reg) ? hi_reg : 3'd7;
        alu_req.start = start_reg;
        alu_req.vmask = vmask;
    end

    assign k       = (alu_rsp.any && alu_rsp.fpos == 3'd0) ? alu_rsp.cnt : 4'd0;
    assign run_sum = {1'b0, run_reg} + {8'd0, k};

    // state register and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg <= first_next;
        last_reg  <= last_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        start_reg <= start_next;
        op_reg    <= op_next;
        n_reg     <= n_next;
        p_reg     <= p_next;
        run_reg   <= run_next;
        nchg_reg  <= nchg_next;
        res_reg   <= res_next;
    end

    // next state and outputs
    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        start_next     = start_reg;
        op_next        = op_reg;
        n_next         = n_reg;
        p_next         = p_reg;
        run_next       = run_reg;
        nchg_next      = nchg_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_ready;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = alu_rsp.edited;

        case (state_reg)
            // zero the store after reset
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = 8'd0;
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(BITMAP_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            // take a request
            ST_IDLE: begin
                if (s_fire) begin
                    res_next   = '0;
                    op_next    = req.req_type;
                    n_next     = size_n;
                    start_next = req.bit_offset[2:0];
                    case (req.req_type)
                        REQ_WRITE: begin
                            mem_we         = 1'b1;
                            mem_waddr      = req.byte_index;
                            mem_wdata      = req.byte_value;
                            out_valid_next = 1'b1;
                        end
                        REQ_READ: begin
                            addr_next  = req.byte_index;
                            state_next = ST_READ_RD;
                        end
                        REQ_SET, REQ_CLEAR, REQ_INVERT: begin
                            if (req.run_length == 16'd0) begin
                                out_valid_next = 1'b1;
                            end else if (off_ext >= size_n ||
                                         end_bit >= {1'b0, size_n}) begin
                                res_next.status = 1'b1;
                                out_valid_next  = 1'b1;
                            end else begin
                                addr_next  = req.bit_offset[14:3];
                                first_next = req.bit_offset[14:3];
                                last_next  = end_bit[14:3];
                                lo_next    = req.bit_offset[2:0];
                                hi_next    = end_bit[2:0];
                                nchg_next  = {1'b0, end_bit[14:3]}
                                           - {1'b0, req.bit_offset[14:3]} + 13'd1;
                                state_next = ST_EDIT_RD;
                            end
                        end
                        REQ_FIND: begin
                            if (off_ext >= size_n) begin
                                res_next.next_start = size_n;
                                out_valid_next      = 1'b1;
                            end else begin
                                addr_next  = req.bit_offset[14:3];
                                state_next = ST_SCAN_RD;
                            end
                        end
                        default: begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ_RD: begin
                state_next = ST_READ_EVAL;
            end
            ST_READ_EVAL: begin
                res_next.read_data = mem_rdata;
                out_valid_next     = 1'b1;
                state_next         = ST_IDLE;
            end
            ST_EDIT_RD: begin
                state_next = ST_EDIT_WR;
            end
            // write back the edited byte
            ST_EDIT_WR: begin
                mem_we = 1'b1;
                if (addr_reg == last_reg) begin
                    res_next.bytes_changed = nchg_reg;
                    res_next.first_byte    = first_reg;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end else begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = ST_EDIT_RD;
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_EVAL;
            end
            // look for the first set bit, then the ones in that byte
            ST_SCAN_EVAL: begin
                if (alu_rsp.any) begin
                    p_next   = {addr_reg, alu_rsp.fpos};
                    run_next = {7'd0, alu_rsp.cnt};
                    if (({1'b0, alu_rsp.fpos} + alu_rsp.cnt) == 4'd8 && byte_end < n_reg) begin
                        addr_next  = addr_reg + ADDR_W'(1);
                        start_next = 3'd0;
                        state_next = ST_RUN_RD;
                    end else begin
                        res_next.found_offset = {addr_reg, alu_rsp.fpos};
                        res_next.found_length = {7'd0, alu_rsp.cnt};
                        res_next.next_start   = {1'b0, addr_reg, alu_rsp.fpos}
                                              + {12'd0, alu_rsp.cnt};
                        out_valid_next        = 1'b1;
                        state_next            = ST_IDLE;
                    end
                end else if (byte_end >= n_reg) begin
                    res_next.next_start = n_reg;
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end else begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    start_next = 3'd0;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_RUN_RD: begin
                state_next = ST_RUN_EVAL;
            end
            // extend the run by whole leading ones of the next byte
            ST_RUN_EVAL: begin
                if (run_sum > 12'(MAX_RUN)) begin
                    res_next.found_offset = p_reg;
                    res_next.found_length = run_reg;
                    res_next.next_start   = {1'b0, p_reg} + {5'd0, run_reg};
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end else if (k != 4'd8 || byte_end >= n_reg) begin
                    res_next.found_offset = p_reg;
                    res_next.found_length = run_sum[10:0];
                    res_next.next_start   = {1'b0, p_reg} + {5'd0, run_sum[10:0]};
                    out_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end else begin
                    run_next   = run_sum[10:0];
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = ST_RUN_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // an accepted request always leaves idle or produces a result
    a_accept_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg != ST_IDLE || out_valid_reg))
        else $error("accepted request left no trace");

    // edit walk never passes the last byte of the run
    a_edit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EDIT_WR) |-> (addr_reg >= first_reg && addr_reg <= last_reg))
        else $error("edit walk outside run");

    // a run being extended stays within the run limit
    a_run_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN_EVAL) |-> (run_reg <= 11'(MAX_RUN)))
        else $error("run exceeds limit");

    // a result waiting on the output holds until taken
    a_res_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(res_reg)))
        else $error("result dropped");
endmodule

// ===== hdl/bitmap_run_modify_and_find.sv =====
// top level: stream ports, size register on the config port, sequencer
// After reset the block zeroes the byte store and holds s_tready low;
// config writes are taken meanwhile. A request is then taken only when
// the block is idle and its last result has been taken. A byte write is
// done in the idle state. A byte read, each byte of a set, clear or invert
// run and each byte that a find scans, up to 129 bytes once the run is
// found, go through a read state and then an evaluate or write state, as
// the single read port of the store has registered data.
module bitmap_run_modify_and_find (
    input  logic        aclk,
    input  logic        aresetn,
    // req_type[2:0], byte_index[14:3], byte_value[22:15], bit_offset[37:23],
    // run_length[53:38], zero fill to 56 bits
    input  logic [55:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // status[0], read_data[8:1], bytes_changed[21:9], first_byte[33:22],
    // found_offset[48:34], found_length[59:49], next_start[75:60], zero fill
    output logic [79:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bmrf_pkg::*;

    logic [15:0] bits_reg;
    logic [15:0] size_n;
    req_t        req;
    res_t        res;

    // size register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bits_reg <= SIZE_CAP;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            bits_reg <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, bits_reg} : 32'd0;
    assign size_n = (bits_reg > SIZE_CAP) ? SIZE_CAP : bits_reg;

    // unpack request beat
    assign req.req_type   = s_tdata[2:0];
    assign req.byte_index = s_tdata[14:3];
    assign req.byte_value = s_tdata[22:15];
    assign req.bit_offset = s_tdata[37:23];
    assign req.run_length = s_tdata[53:38];

    bmrf_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .req     (req),
        .size_n  (size_n),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .res     (res)
    );

    // pack result beat
    assign m_tdata = {4'd0, res.next_start, res.found_length, res.found_offset,
                      res.first_byte, res.bytes_changed, res.read_data, res.status};
endmodule

// ===== dv/bitmap_run_modify_and_find_tb.sv =====
// testbench for the bitmap run modify and find block: directed table, random requests, predictor
module bitmap_run_modify_and_find_tb;
    import bmrf_pkg::*;

    localparam int RANDOM_ITEMS = 1420;
    localparam int CYCLE_LIMIT  = 60000000;
    localparam logic [2:0] ADDR_SIZE = 3'd0;

    logic        aclk;
    logic        aresetn;
    logic [55:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    bitmap_run_modify_and_find uut (.*);

    // predictor state
    logic [7:0]  shadow_map [BITMAP_BYTES];
    logic [15:0] shadow_bits;
    res_t        pending_results[$];
    int          error_count;
    int          result_count;
    int          cycle_count;
    bit          hold_off;
    int          edits_seen, finds_hit, oob_seen;

    // directed table row: request plus optional typed-in result
    typedef struct {
        req_t req;
        bit   known;
        res_t res;
    } dir_row_t;

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic logic map_bit(int unsigned pos);
        return shadow_map[pos >> 3][pos & 7];
    endfunction

    // compute expected result and update shadow bitmap
    function automatic res_t predict_request(req_t r);
        res_t        o;
        int unsigned n, p, q, lim, bend, byte_end, run, k, off, len;
        o = '0;
        n = (shadow_bits < SIZE_CAP) ? shadow_bits : SIZE_CAP;
        off = r.bit_offset;
        len = r.run_length;
        case (r.req_type)
            REQ_WRITE: shadow_map[r.byte_index] = r.byte_value;
            REQ_READ:  o.read_data = shadow_map[r.byte_index];
            REQ_SET, REQ_CLEAR, REQ_INVERT: begin
                if (len != 0) begin
                    if (off >= n || off + len > n) begin
                        o.status = 1'b1;
                    end else begin
                        for (int unsigned i = off; i < off + len; i++) begin
                            if (r.req_type == REQ_SET)
                                shadow_map[i >> 3][i & 7] = 1'b1;
                            else if (r.req_type == REQ_CLEAR)
                                shadow_map[i >> 3][i & 7] = 1'b0;
                            else
                                shadow_map[i >> 3][i & 7] = ~shadow_map[i >> 3][i & 7];
                        end
                        o.first_byte    = 12'(off >> 3);
                        o.bytes_changed = 13'(((off + len - 1) >> 3) - (off >> 3) + 1);
                    end
                end
            end
            REQ_FIND: begin
                p = off;
                o.next_start = 16'(n);
                while (p < n && map_bit(p) == 1'b0)
                    p++;
                if (p < n) begin
                    byte_end = (p | 7) + 1;
                    lim = (byte_end < n) ? byte_end : n;
                    q = p;
                    while (q < lim && map_bit(q))
                        q++;
                    run = q - p;
                    if (q == byte_end && byte_end < n) begin
                        forever begin
                            bend = (q + 8 < n) ? q + 8 : n;
                            k = 0;
                            while (q + k < bend && map_bit(q + k))
                                k++;
                            if (run + k > MAX_RUN)
                                break;
                            run += k;
                            q += k;
                            if (k < 8 || q >= n)
                                break;
                        end
                    end
                    o.found_offset = 15'(p);
                    o.found_length = 11'(run);
                    o.next_start   = 16'(p + run);
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic logic [55:0] pack_req(req_t r);
        return {2'b00, r.run_length, r.bit_offset, r.byte_value, r.byte_index, r.req_type};
    endfunction

    function automatic res_t unpack_res(logic [79:0] d);
        res_t o;
        o.status        = d[0];
        o.read_data     = d[8:1];
        o.bytes_changed = d[21:9];
        o.first_byte    = d[33:22];
        o.found_offset  = d[48:34];
        o.found_length  = d[59:49];
        o.next_start    = d[75:60];
        return o;
    endfunction

    function automatic req_t make_req(logic [2:0] kind, int unsigned idx, int unsigned val,
                                      int unsigned off, int unsigned len);
        req_t r;
        r.req_type   = kind;
        r.byte_index = 12'(idx);
        r.byte_value = 8'(val);
        r.bit_offset = 15'(off);
        r.run_length = 16'(len);
        return r;
    endfunction

    // random request, mostly well-formed edits and finds within the size
    function automatic req_t random_req();
        req_t        r;
        int unsigned n, sel, off;
        n = (shadow_bits < SIZE_CAP) ? shadow_bits : SIZE_CAP;
        r = make_req(3'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom);
        sel = $urandom_range(0, 99);
        if (sel < 75) begin
            off = $urandom_range(0, n - 1);
            r.bit_offset = 15'(off);
            if ($urandom_range(0, 9) == 0)
                r.run_length = 16'($urandom_range(0, n - off));
            else
                r.run_length = 16'($urandom_range(0, ((n - off) < 64) ? n - off : 64));
            r.req_type = (sel < 20) ? REQ_FIND : 3'($urandom_range(REQ_SET, REQ_FIND));
            if (sel < 8) begin
                r.req_type   = REQ_WRITE;
                r.byte_value = ($urandom_range(0, 1) != 0) ? 8'hff : 8'($urandom);
            end
        end else if (sel < 85) begin
            r.req_type = 3'($urandom_range(REQ_WRITE, REQ_READ));
        end
        return r;
    endfunction

    // one apb write, setup then access
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_bits = data[15:0];
    endtask

    // offer one beat after a random gap, predict on acceptance
    task automatic send_req(req_t r, bit known, res_t res);
        res_t o;
        int   gap;
        gap = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 16) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap)
                @(posedge aclk);
        end
        s_tdata  <= pack_req(r);
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        o = predict_request(r);
        if (known && o != res) begin
            $display("%0t table mismatch: expected %h actual %h", $time, res, o);
            error_count++;
        end
        if (r.req_type inside {REQ_SET, REQ_CLEAR, REQ_INVERT})
            edits_seen++;
        if (o.status)
            oob_seen++;
        if (o.found_length != 0)
            finds_hit++;
        pending_results.push_back(o);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (300)
            @(posedge aclk);
    endtask

    // result side: random stalls, compare each beat
    initial begin
        res_t got, want;
        int   gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                @(posedge aclk);
            end else begin
                gap = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 16) : 0;
                m_tready <= (gap == 0);
                @(posedge aclk);
                if (m_tvalid && m_tready) begin
                    got = unpack_res(m_tdata);
                    result_count++;
                    if (pending_results.size() == 0) begin
                        $display("%0t unexpected beat: expected none actual %h", $time, got);
                        error_count++;
                    end else begin
                        want = pending_results.pop_front();
                        if (got != want) begin
                            $display("%0t result mismatch: expected %h actual %h",
                                     $time, want, got);
                            error_count++;
                        end
                    end
                end
                if (gap != 0) begin
                    repeat (gap - 1)
                        @(posedge aclk);
                end
            end
        end
    end

    // long receiver hold-off, counted here
    initial begin
        hold_off = 1'b0;
        @(posedge aresetn);
        repeat (9000)
            @(posedge aclk);
        hold_off = 1'b1;
        repeat (3000)
            @(posedge aclk);
        hold_off = 1'b0;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("status: fail");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        dir_row_t    table_rows[$];
        dir_row_t    row;
        res_t        z;
        logic [15:0] sizes [4];
        aresetn  = 1'b0;
        s_tdata  = '0;
        s_tvalid = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        error_count = 0;
        result_count = 0;
        edits_seen = 0;
        finds_hit = 0;
        oob_seen = 0;
        shadow_bits = SIZE_CAP;
        foreach (shadow_map[i])
            shadow_map[i] = 8'h00;
        repeat (11)
            @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, results typed where obvious
        z = '0;
        row.known = 1'b1; row.res = z;
        row.req = make_req(REQ_READ, 0, 0, 0, 0);             table_rows.push_back(row);
        row.res = z; row.res.next_start = 16'd32768;
        row.req = make_req(REQ_FIND, 0, 0, 0, 0);             table_rows.push_back(row);
        row.req = make_req(REQ_FIND, 0, 0, 32767, 0);         table_rows.push_back(row);
        row.res = z;
        row.req = make_req(REQ_SET, 0, 0, 5, 0);              table_rows.push_back(row);
        row.res = z; row.res.status = 1'b1;
        row.req = make_req(REQ_SET, 0, 0, 32767, 2);          table_rows.push_back(row);
        row.req = make_req(REQ_INVERT, 0, 0, 0, 16'hffff);    table_rows.push_back(row);
        row.res = z;
        row.req = make_req(3'd6, 12'hfff, 8'hff, 15'h7fff, 16'hffff); table_rows.push_back(row);
        row.req = make_req(3'd7, 0, 0, 0, 0);                 table_rows.push_back(row);
        row.req = make_req(REQ_WRITE, 12'hfff, 8'hff, 0, 0);  table_rows.push_back(row);
        row.res = z; row.res.read_data = 8'hff;
        row.req = make_req(REQ_READ, 12'hfff, 0, 0, 0);       table_rows.push_back(row);
        row.res = z; row.res.first_byte = 12'd0; row.res.bytes_changed = 13'd4096;
        row.req = make_req(REQ_SET, 0, 0, 0, 32768);          table_rows.push_back(row);
        row.known = 1'b0;
        row.req = make_req(REQ_FIND, 0, 0, 3, 0);             table_rows.push_back(row);
        row.req = make_req(REQ_FIND, 0, 0, 32760, 0);         table_rows.push_back(row);
        row.req = make_req(REQ_CLEAR, 0, 0, 1, 32767);        table_rows.push_back(row);
        row.req = make_req(REQ_INVERT, 0, 0, 13, 2000);       table_rows.push_back(row);
        row.req = make_req(REQ_FIND, 0, 0, 0, 0);             table_rows.push_back(row);
        row.req = make_req(REQ_FIND, 0, 0, 14, 0);            table_rows.push_back(row);
        row.req = make_req(REQ_WRITE, 5, 8'h0f, 0, 0);        table_rows.push_back(row);
        row.req = make_req(REQ_WRITE, 6, 8'hf0, 0, 0);        table_rows.push_back(row);
        row.req = make_req(REQ_FIND, 0, 0, 40, 0);            table_rows.push_back(row);
        row.req = make_req(REQ_READ, 2, 0, 0, 0);             table_rows.push_back(row);
        foreach (table_rows[i])
            send_req(table_rows[i].req, table_rows[i].known, table_rows[i].res);
        drain();

        // random phases across sizes, extremes included
        sizes = '{16'd1, 16'd100, 16'hffff, 16'd32768};
        for (int ph = 0; ph < 4; ph++) begin
            apb_write(ADDR_SIZE, {16'h0, sizes[ph]});
            if (sizes[ph] == 16'd1)
                send_req(make_req(REQ_SET, 0, 0, 0, 2), 1'b1, '{status: 1'b1, default: '0});
            for (int i = 0; i < RANDOM_ITEMS / 4; i++)
                send_req(random_req(), 1'b0, '0);
            drain();
        end

        $display("covered %0d beats: %0d run edits, %0d out of bounds, %0d runs found",
                 result_count, edits_seen, oob_seen, finds_hit);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bmrf_pkg.sv
hdl/bmrf_mem.sv
hdl/bmrf_byte_alu.sv
hdl/bmrf_seq.sv
hdl/bitmap_run_modify_and_find.sv
dv/bitmap_run_modify_and_find_tb.sv
